### rtl/mhpq_pkg.sv
// Shared constants, codes and types for the min-heap priority queue.
package mhpq_pkg;

	localparam int HEAP_DEPTH  = 64;
	localparam int VALUE_WIDTH = 16;
	localparam int ADDR_W      = $clog2(HEAP_DEPTH);
	localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);

	// fixed port widths
	localparam int OPCODE_W = 2;
	localparam int VALUE_W  = 16;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 7;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_DRAIN   = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_UP_FIN,
		S_DN_TOP,
		S_DN_TOP2,
		S_DN_RD,
		S_DN_CMP,
		S_DN_FIN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
	} mem_rd_t;

	typedef struct packed {
		logic                   en;
		logic [ADDR_W-1:0]      addr;
		logic [VALUE_WIDTH-1:0] data;
	} mem_wr_t;

endpackage

### rtl/min_heap_priority_queue.sv
// Min-heap priority queue: top level with sequencer and output register.
//
// Input channel (in_valid/in_ready) takes opcode and value; output channel
// (out_valid/out_ready) returns result_value, status, entries_left, last.
// Insert appends the value and sifts it toward the root; extract returns the
// minimum and sifts the last entry down from the root; drain repeats extract
// until empty, one transfer per entry, last set on the final one. Insert on
// a full heap or extract/drain on an empty one gives one error result.
// One item is in work at a time; in_ready is high only while idle.
// Insert compares the value with its parents on the way up; extract reads
// the root and the last entry, then descends level by level, and skips
// the descent when it empties the heap; error and no-op results go
// straight to the output register. Each level of the descent is one read
// of both children from the memory and one write-back. Drain: the extract
// sequence once per entry. in_ready returns in the cycle after a final load.
// A result sits in the output register until taken; the block may accept
// the next item meanwhile, but holds its next result while the receiver
// stalls. Reset empties the heap (count to zero) and clears out_valid; the
// storage itself is not cleared and needs no sweep.
module min_heap_priority_queue import mhpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VALUE_W-1:0]  result_value,
	output logic [STATUS_W-1:0] status,
	output logic [ENTRY_W-1:0]  entries_left,
	output logic                last
);

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	op_t                    op_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [ADDR_W-1:0]      j_q;
	logic [ADDR_W-1:0]      h_q;
	logic [VALUE_WIDTH-1:0] mov_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	status_t                res_st_q;
	logic [VALUE_W-1:0]     out_val_q;
	status_t                out_st_q;
	logic [ENTRY_W-1:0]     out_cnt_q;
	logic                   out_last_q;

	mem_rd_t                rd;
	mem_wr_t                wr;
	logic [VALUE_WIDTH-1:0] rdata_a, rdata_b;

	logic                   in_xfer;
	logic                   out_load;
	logic                   full, empty;
	logic [ADDR_W-1:0]      parent;
	logic [ADDR_W+1:0]      c_e, c1_e, cnt_e;
	logic                   use_right;
	logic [ADDR_W-1:0]      child;
	logic [VALUE_WIDTH-1:0] child_v;
	logic                   stop_dn;
	logic                   swap_up;
	logic                   more_drain;

	mhpq_mem u_mem (
		.clk     (clk),
		.rd      (rd),
		.wr      (wr),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(HEAP_DEPTH));
	assign empty    = (count_q == '0);
	assign parent   = ADDR_W'((j_q - 1'b1) >> 1);

	// children of the hole: 2h+1 and 2h+2
	assign c_e       = (ADDR_W+2)'({h_q, 1'b1});
	assign c1_e      = c_e + 1'b1;
	assign cnt_e     = (ADDR_W+2)'(count_q);
	assign use_right = (c1_e < cnt_e) && (rdata_b < rdata_a);
	assign child     = use_right ? c1_e[ADDR_W-1:0] : c_e[ADDR_W-1:0];
	assign child_v   = use_right ? rdata_b : rdata_a;
	assign stop_dn   = (mov_q < child_v);
	assign swap_up   = (rdata_a >= val_q);

	assign out_load   = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign more_drain = (op_q == OP_DRAIN) && (res_st_q == ST_OK) && !empty;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (op_t'(opcode))
						OP_INSERT: begin
							if (full) state_d = S_EMIT;
							else if (empty) state_d = S_UP_FIN;
							else state_d = S_UP_RD;
						end
						OP_EXTRACT, OP_DRAIN: begin
							state_d = empty ? S_EMIT : S_DN_TOP;
						end
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_UP_RD:   state_d = S_UP_CMP;
			S_UP_CMP: begin
				if (swap_up && parent != '0) state_d = S_UP_RD;
				else state_d = S_UP_FIN;
			end
			S_UP_FIN:  state_d = S_EMIT;
			S_DN_TOP:  state_d = S_DN_TOP2;
			S_DN_TOP2: state_d = empty ? S_EMIT : S_DN_RD;
			S_DN_RD:   state_d = (c_e >= cnt_e) ? S_DN_FIN : S_DN_CMP;
			S_DN_CMP:  state_d = stop_dn ? S_DN_FIN : S_DN_RD;
			S_DN_FIN:  state_d = S_EMIT;
			S_EMIT: begin
				if (out_load) state_d = more_drain ? S_DN_TOP : S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		rd      = '0;
		wr      = '0;
		case (state_q)
			S_UP_RD: begin
				rd.addr_a = parent;
			end
			S_UP_CMP: begin
				wr.en   = swap_up;
				wr.addr = j_q;
				wr.data = rdata_a;
			end
			S_UP_FIN: begin
				wr.en   = 1'b1;
				wr.addr = j_q;
				wr.data = val_q;
			end
			S_DN_TOP: begin
				rd.addr_a = '0;
				rd.addr_b = ADDR_W'(count_q - 1'b1);
			end
			S_DN_RD: begin
				rd.addr_a = c_e[ADDR_W-1:0];
				rd.addr_b = c1_e[ADDR_W-1:0];
			end
			S_DN_CMP: begin
				wr.en   = !stop_dn;
				wr.addr = h_q;
				wr.data = child_v;
			end
			S_DN_FIN: begin
				wr.en   = 1'b1;
				wr.addr = h_q;
				wr.data = mov_q;
			end
			default: begin
				rd = '0;
				wr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (in_xfer && op_t'(opcode) == OP_INSERT && !full) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == S_DN_TOP) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					op_q      <= op_t'(opcode);
					val_q     <= VALUE_WIDTH'(value);
					j_q       <= ADDR_W'(count_q);
					res_val_q <= '0;
					case (op_t'(opcode))
						OP_INSERT:            res_st_q <= full ? ST_FULL : ST_OK;
						OP_EXTRACT, OP_DRAIN: res_st_q <= empty ? ST_EMPTY : ST_OK;
						default:              res_st_q <= ST_OK;
					endcase
				end
			end
			S_UP_CMP: begin
				if (swap_up) j_q <= parent;
			end
			S_DN_TOP2: begin
				res_val_q <= rdata_a;
				mov_q     <= rdata_b;
				h_q       <= '0;
			end
			S_DN_CMP: begin
				if (!stop_dn) h_q <= child;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_val_q  <= VALUE_W'(res_val_q);
			out_st_q   <= res_st_q;
			out_cnt_q  <= ENTRY_W'(count_q);
			out_last_q <= !more_drain;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_val_q;
	assign status       = out_st_q;
	assign entries_left = out_cnt_q;
	assign last         = out_last_q;

	// heap never holds more than its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HEAP_DEPTH))
		else $error("entry count beyond heap depth");

	// every write lands inside the live part of the heap
	a_write_live: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (CNT_W'(wr.addr) < count_q))
		else $error("heap write outside live entries");

	// only a drain with entries still held gives a non-final result
	a_nonlast_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (status == ST_OK && entries_left != '0))
		else $error("non-final result with error or empty heap");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken while busy");

endmodule

### rtl/mhpq_mem.sv
// Heap storage: one write port, two registered read ports.
module mhpq_mem import mhpq_pkg::*; (
	input  logic                   clk,
	input  mem_rd_t                rd,
	input  mem_wr_t                wr,
	output logic [VALUE_WIDTH-1:0] rdata_a,
	output logic [VALUE_WIDTH-1:0] rdata_b
);

	logic [VALUE_WIDTH-1:0] mem [HEAP_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[rd.addr_a];
		rdata_b <= mem[rd.addr_b];
	end

endmodule
